// ===== rtl/core/bti_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and saturation helper for the bicubic table interpolator.
// No dependencies.
package bti_pkg;

   localparam int GRID_MAX_AXIS1_DEF = 32;
   localparam int GRID_MAX_AXIS2_DEF = 32;
   localparam int COMPONENTS_MAX_DEF = 4;
   localparam int COEFS_PER_CELL     = 16;

   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X1     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X2     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP_STEP_X1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP_STEP_X2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS_AXIS1  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS_AXIS2  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COMP_COUNT    = 3'd6;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   // result kinds, in the order they are accumulated
   localparam logic [2:0] D_VAL   = 3'd0;
   localparam logic [2:0] D_DX1   = 3'd1;
   localparam logic [2:0] D_DX2   = 3'd2;
   localparam logic [2:0] D_DX1X1 = 3'd3;
   localparam logic [2:0] D_DX1X2 = 3'd4;
   localparam logic [2:0] D_DX2X2 = 3'd5;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -66'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

// ===== rtl/core/bti_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bicubic_table_interpolator_top.sv =====
`timescale 1ns / 1ps
// Top level of the bicubic table interpolator: sequencer, shared multiplier, results.
// Depends on bti_pkg and bti_ram.
//
// Usage
//  - req_* channel: one transfer per item. req_type = load writes req_coef_word
//    to coefficient table address req_coef_index (addresses past the table are
//    dropped); req_type = evaluate interpolates at (req_point_x1, req_point_x2).
//  - rsp_* channel: one transfer per function component of an evaluation, with
//    value, both first derivatives, the three second derivatives (Q16.16,
//    saturated) and rsp_last_component on the final one. Loads give nothing.
//  - csr_* channel: register writes, always ready; write only while idle.
// Timing
//  - A load is taken and req_ready stays high.
//  - An evaluation holds req_ready low while it runs:
//    everything runs through one 33x33 signed multiplier with a registered
//    product. Setup (cell search, powers, 16 monomials, table address) comes
//    first; each component then builds 96 weights on the fly and
//    multiply-accumulates them against the table.
// Reset: synchronous, clears the sequencer and the output valid, and returns
//  the registers to their defaults. The table is not cleared: every entry must
//  be loaded before an evaluation reads it.
// Stalls: a finished result waits in the output register; the sequencer only
//  stops when the next component is ready and the previous one is still held.
module bicubic_table_interpolator_top
   #(
   parameter int GRID_MAX_AXIS1 = bti_pkg::GRID_MAX_AXIS1_DEF,
   parameter int GRID_MAX_AXIS2 = bti_pkg::GRID_MAX_AXIS2_DEF,
   parameter int COMPONENTS_MAX = bti_pkg::COMPONENTS_MAX_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_type,
   input  logic [15:0]                    req_coef_index,
   input  logic signed [31:0]             req_coef_word,
   input  logic signed [31:0]             req_point_x1,
   input  logic signed [31:0]             req_point_x2,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_component,
   output logic signed [31:0]             rsp_interp_value,
   output logic signed [31:0]             rsp_deriv_x1,
   output logic signed [31:0]             rsp_deriv_x2,
   output logic signed [31:0]             rsp_deriv_x1x1,
   output logic signed [31:0]             rsp_deriv_x1x2,
   output logic signed [31:0]             rsp_deriv_x2x2,
   output logic                           rsp_last_component,
   // register write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bti_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_wdata
);
   import bti_pkg::*;

   localparam int CELLS       = (GRID_MAX_AXIS1 - 1) * (GRID_MAX_AXIS2 - 1);
   localparam int SLOTS       = COMPONENTS_MAX * CELLS;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CIDX_W      = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int ADDR_W      = SLOT_W + 4;
   localparam int TABLE_DEPTH = COEFS_PER_CELL * SLOTS;
   localparam int RAM_DEPTH   = 1 << ADDR_W;
   localparam int CELL1_W     = $clog2(GRID_MAX_AXIS1);
   localparam int CELL2_W     = $clog2(GRID_MAX_AXIS2);
   localparam int CNT_W       = $clog2(COMPONENTS_MAX + 1);
   localparam int ACC_W       = 62;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0_0000_0000_0001,
      S_LOC1   = 13'b0_0000_0000_0010,
      S_LOC2   = 13'b0_0000_0000_0100,
      S_POW    = 13'b0_0000_0000_1000,
      S_MVS    = 13'b0_0000_0001_0000,
      S_CIDX   = 13'b0_0000_0010_0000,
      S_CBASE  = 13'b0_0000_0100_0000,
      S_WSTART = 13'b0_0000_1000_0000,
      S_WINT   = 13'b0_0001_0000_0000,
      S_WS1    = 13'b0_0010_0000_0000,
      S_WS2    = 13'b0_0100_0000_0000,
      S_MAC    = 13'b0_1000_0000_0000,
      S_EMIT   = 13'b1_0000_0000_0000
   } state_type;

   // configuration
   logic signed [31:0] org1_ff, org2_ff;
   logic [31:0]        rcp1_ff, rcp2_ff;
   logic [5:0]         npts1_ff, npts2_ff;
   logic [2:0]         ccount_ff;

   // sequencer
   state_type          state_ff, state_in;
   logic               ph_ff, ph_in;
   logic [1:0]         pj_ff, pj_in;
   logic [3:0]         k_ff, k_in;
   logic [2:0]         d_ff, d_in;
   logic [CNT_W-1:0]   comp_ff, comp_in;

   // datapath
   logic signed [31:0] px1_ff, px1_in, px2_ff, px2_in;
   logic [CELL1_W-1:0] c1_ff, c1_in;
   logic [CELL2_W-1:0] c2_ff, c2_in;
   logic signed [31:0] pw1_ff [4];
   logic signed [31:0] pw1_in [4];
   logic signed [31:0] pw2_ff [4];
   logic signed [31:0] pw2_in [4];
   logic signed [31:0] mv_ff [16];
   logic signed [31:0] mv_in [16];
   logic [CIDX_W-1:0]  cidx_ff, cidx_in;
   logic [SLOT_W-1:0]  cbase_ff, cbase_in;
   logic signed [31:0] w_ff, w_in;
   logic [3:0]         fac_ff, fac_in;
   logic               two_ff, two_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [31:0] res_ff [6];
   logic signed [31:0] res_in [6];
   logic signed [65:0] prod_ff;
   logic signed [32:0] mul_a, mul_b;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_comp_ff, rsp_comp_in;
   logic signed [31:0] rsp_f_ff [6];
   logic signed [31:0] rsp_f_in [6];
   logic               rsp_last_ff, rsp_last_in;

   // clamped grid sizes
   logic [CELL1_W-1:0] top1;
   logic [CELL2_W-1:0] top2, n2m1;
   logic [CNT_W-1:0]   cnt;

   always_comb begin
      int n1_i, n2_i, c_i;
      if (npts1_ff < 6'd2) n1_i = 2;
      else if (int'(npts1_ff) > GRID_MAX_AXIS1) n1_i = GRID_MAX_AXIS1;
      else n1_i = int'(npts1_ff);
      if (npts2_ff < 6'd2) n2_i = 2;
      else if (int'(npts2_ff) > GRID_MAX_AXIS2) n2_i = GRID_MAX_AXIS2;
      else n2_i = int'(npts2_ff);
      if (ccount_ff == 3'd0) c_i = 1;
      else if (int'(ccount_ff) > COMPONENTS_MAX) c_i = COMPONENTS_MAX;
      else c_i = int'(ccount_ff);
      top1 = CELL1_W'(n1_i - 2);
      top2 = CELL2_W'(n2_i - 2);
      n2m1 = CELL2_W'(n2_i - 1);
      cnt  = CNT_W'(c_i);
   end

   // handshakes
   logic req_xfer, load_xfer, eval_xfer, rsp_free;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;
   assign load_xfer = req_xfer && (req_type == REQ_LOAD);
   assign eval_xfer = req_xfer && (req_type == REQ_EVAL);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // coefficient table
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [31:0]       ram_rdata;
   logic [SLOT_W-1:0] slot;

   assign ram_we    = load_xfer && (32'(req_coef_index) < 32'(TABLE_DEPTH));
   assign ram_waddr = ADDR_W'(req_coef_index);
   assign slot      = SLOT_W'(cbase_ff + SLOT_W'(comp_ff));
   assign ram_raddr = {slot, k_ff};

   bti_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_coef_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_coef_word),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // weight selection for the current (kind, monomial)
   logic [1:0]  pe, qe;
   logic [3:0]  w_src, w_fac;
   logic        w_zero, w_two;
   logic [31:0] rcpa, rcpb;

   assign pe = k_ff[3:2];
   assign qe = k_ff[1:0];

   always_comb begin
      w_src  = k_ff;
      w_fac  = 4'd1;
      w_zero = 1'b0;
      w_two  = 1'b0;
      unique case (d_ff)
         D_VAL: begin
         end
         D_DX1: begin
            w_src  = k_ff - 4'd4;
            w_fac  = 4'(pe);
            w_zero = (pe == 2'd0);
         end
         D_DX2: begin
            w_src  = k_ff - 4'd1;
            w_fac  = 4'(qe);
            w_zero = (qe == 2'd0);
         end
         D_DX1X1: begin
            w_src  = k_ff - 4'd8;
            w_fac  = 4'(4'(pe) * 4'(pe - 2'd1));
            w_zero = (pe < 2'd2);
            w_two  = 1'b1;
         end
         D_DX1X2: begin
            w_src  = k_ff - 4'd5;
            w_fac  = 4'(4'(pe) * 4'(qe));
            w_zero = (pe == 2'd0) || (qe == 2'd0);
            w_two  = 1'b1;
         end
         D_DX2X2: begin
            w_src  = k_ff - 4'd2;
            w_fac  = 4'(4'(qe) * 4'(qe - 2'd1));
            w_zero = (qe < 2'd2);
            w_two  = 1'b1;
         end
         default: begin
            w_zero = 1'b1;
         end
      endcase
      rcpa = ((d_ff == D_DX2) || (d_ff == D_DX2X2)) ? rcp2_ff : rcp1_ff;
      rcpb = (d_ff == D_DX1X1) ? rcp1_ff : rcp2_ff;
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_LOC1: begin
            mul_a = 33'(px1_ff) - 33'(org1_ff);
            mul_b = {1'b0, rcp1_ff};
         end
         S_LOC2: begin
            mul_a = 33'(px2_ff) - 33'(org2_ff);
            mul_b = {1'b0, rcp2_ff};
         end
         S_POW: begin
            unique case (pj_ff)
               2'd0:    begin mul_a = 33'(pw1_ff[1]); mul_b = 33'(pw1_ff[1]); end
               2'd1:    begin mul_a = 33'(pw1_ff[2]); mul_b = 33'(pw1_ff[1]); end
               2'd2:    begin mul_a = 33'(pw2_ff[1]); mul_b = 33'(pw2_ff[1]); end
               default: begin mul_a = 33'(pw2_ff[2]); mul_b = 33'(pw2_ff[1]); end
            endcase
         end
         S_MVS: begin
            mul_a = 33'(pw1_ff[pe]);
            mul_b = 33'(pw2_ff[qe]);
         end
         S_CIDX: begin
            mul_a = 33'(n2m1);
            mul_b = 33'(c1_ff);
         end
         S_CBASE: begin
            mul_a = 33'(cnt);
            mul_b = 33'(cidx_ff);
         end
         S_WINT: begin
            mul_a = 33'(w_ff);
            mul_b = 33'(fac_ff);
         end
         S_WS1: begin
            mul_a = 33'(w_ff);
            mul_b = {1'b0, rcpa};
         end
         S_WS2: begin
            mul_a = 33'(w_ff);
            mul_b = {1'b0, rcpb};
         end
         S_MAC: begin
            mul_a = 33'($signed(ram_rdata));
            mul_b = 33'(w_ff);
         end
         default: begin
         end
      endcase
   end

   // post-processing of the registered product
   logic signed [31:0] q_sat, i_sat;
   logic signed [49:0] t_v, top_sh;
   logic signed [33:0] tc_v, top_v, cell_v;
   logic signed [31:0] frac_v;

   assign q_sat = sat32(prod_ff >>> 16);
   assign i_sat = sat32(prod_ff);

   // cell search: clamp to the grid, the edge cell extrapolates
   always_comb begin
      t_v   = prod_ff[65:16];
      tc_v  = t_v[49:16];
      top_v = (state_ff == S_LOC1) ? 34'(top1) : 34'(top2);
      top_sh = {top_v, 16'h0000};
      if (tc_v < 34'sd0) begin
         cell_v = '0;
         frac_v = sat32(66'(t_v));
      end else if (tc_v > top_v) begin
         cell_v = top_v;
         frac_v = sat32(66'(t_v - top_sh));
      end else begin
         cell_v = tc_v;
         frac_v = {16'h0000, t_v[15:0]};
      end
   end

   // accumulator and end-of-weight advance
   logic signed [ACC_W-1:0] acc_sum;
   logic                    is_mac_wb, adv;

   assign is_mac_wb = (state_ff == S_MAC) && ph_ff;
   assign acc_sum   = is_mac_wb ? (acc_ff + ACC_W'(prod_ff >>> 8)) : acc_ff;
   assign adv       = is_mac_wb || ((state_ff == S_WSTART) && (d_ff != D_VAL) && w_zero);

   logic [CNT_W:0] comp_nxt;
   assign comp_nxt = (CNT_W + 1)'(comp_ff) + (CNT_W + 1)'(1);

   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      pj_in        = pj_ff;
      k_in         = k_ff;
      d_in         = d_ff;
      comp_in      = comp_ff;
      px1_in       = px1_ff;
      px2_in       = px2_ff;
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      pw1_in       = pw1_ff;
      pw2_in       = pw2_ff;
      mv_in        = mv_ff;
      cidx_in      = cidx_ff;
      cbase_in     = cbase_ff;
      w_in         = w_ff;
      fac_in       = fac_ff;
      two_in       = two_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_comp_in  = rsp_comp_ff;
      rsp_f_in     = rsp_f_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (eval_xfer) begin
               px1_in   = req_point_x1;
               px2_in   = req_point_x2;
               ph_in    = 1'b0;
               state_in = S_LOC1;
            end
         end
         S_LOC1: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               c1_in     = CELL1_W'(cell_v);
               pw1_in[0] = Q_ONE;
               pw1_in[1] = frac_v;
               state_in  = S_LOC2;
            end
         end
         S_LOC2: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               c2_in     = CELL2_W'(cell_v);
               pw2_in[0] = Q_ONE;
               pw2_in[1] = frac_v;
               pj_in     = 2'd0;
               state_in  = S_POW;
            end
         end
         S_POW: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               pj_in = pj_ff + 2'd1;
               unique case (pj_ff)
                  2'd0:    pw1_in[2] = q_sat;
                  2'd1:    pw1_in[3] = q_sat;
                  2'd2:    pw2_in[2] = q_sat;
                  default: begin
                     pw2_in[3] = q_sat;
                     k_in      = 4'd0;
                     state_in  = S_MVS;
                  end
               endcase
            end
         end
         S_MVS: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               mv_in[k_ff] = q_sat;
               k_in        = k_ff + 4'd1;
               if (k_ff == 4'd15) begin
                  state_in = S_CIDX;
               end
            end
         end
         S_CIDX: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               cidx_in  = CIDX_W'(CIDX_W'(prod_ff) + CIDX_W'(c2_ff));
               state_in = S_CBASE;
            end
         end
         S_CBASE: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               cbase_in = SLOT_W'(prod_ff);
               comp_in  = '0;
               d_in     = D_VAL;
               k_in     = 4'd0;
               acc_in   = '0;
               state_in = S_WSTART;
            end
         end
         S_WSTART: begin
            // also lets the registered table read for this monomial complete before the multiply
            w_in   = mv_ff[w_src];
            fac_in = w_fac;
            two_in = w_two;
            ph_in  = 1'b0;
            if (d_ff == D_VAL) begin
               state_in = S_MAC;
            end else if (!w_zero) begin
               state_in = S_WINT;
            end
         end
         S_WINT: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               w_in     = i_sat;
               state_in = S_WS1;
            end
         end
         S_WS1: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               w_in     = q_sat;
               state_in = two_ff ? S_WS2 : S_MAC;
            end
         end
         S_WS2: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               w_in     = q_sat;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            ph_in = !ph_ff;
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_comp_in  = 2'(comp_ff);
               rsp_f_in     = res_ff;
               rsp_last_in  = (comp_nxt == (CNT_W + 1)'(cnt));
               comp_in      = CNT_W'(comp_nxt);
               d_in         = D_VAL;
               k_in         = 4'd0;
               acc_in       = '0;
               state_in     = (comp_nxt == (CNT_W + 1)'(cnt)) ? S_IDLE : S_WSTART;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (adv) begin
         acc_in = acc_sum;
         k_in   = k_ff + 4'd1;
         state_in = S_WSTART;
         if (k_ff == 4'd15) begin
            res_in[d_ff] = sat32(66'(acc_sum) >>> 8);
            acc_in       = '0;
            if (d_ff == D_DX2X2) begin
               state_in = S_EMIT;
            end else begin
               d_in = d_ff + 3'd1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ph_ff        <= 1'b0;
         pj_ff        <= 2'd0;
         k_ff         <= 4'd0;
         d_ff         <= D_VAL;
         comp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         org1_ff      <= '0;
         org2_ff      <= '0;
         rcp1_ff      <= 32'h0001_0000;
         rcp2_ff      <= 32'h0001_0000;
         npts1_ff     <= 6'd2;
         npts2_ff     <= 6'd2;
         ccount_ff    <= 3'd1;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         pj_ff        <= pj_in;
         k_ff         <= k_in;
         d_ff         <= d_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ORIGIN_X1:     org1_ff   <= csr_wdata;
               CSR_ORIGIN_X2:     org2_ff   <= csr_wdata;
               CSR_RECIP_STEP_X1: rcp1_ff   <= csr_wdata;
               CSR_RECIP_STEP_X2: rcp2_ff   <= csr_wdata;
               CSR_POINTS_AXIS1:  npts1_ff  <= csr_wdata[5:0];
               CSR_POINTS_AXIS2:  npts2_ff  <= csr_wdata[5:0];
               CSR_COMP_COUNT:    ccount_ff <= csr_wdata[2:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff     <= mul_a * mul_b;
      px1_ff      <= px1_in;
      px2_ff      <= px2_in;
      c1_ff       <= c1_in;
      c2_ff       <= c2_in;
      pw1_ff      <= pw1_in;
      pw2_ff      <= pw2_in;
      mv_ff       <= mv_in;
      cidx_ff     <= cidx_in;
      cbase_ff    <= cbase_in;
      w_ff        <= w_in;
      fac_ff      <= fac_in;
      two_ff      <= two_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      rsp_comp_ff <= rsp_comp_in;
      rsp_f_ff    <= rsp_f_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_component      = rsp_comp_ff;
   assign rsp_interp_value   = rsp_f_ff[D_VAL];
   assign rsp_deriv_x1       = rsp_f_ff[D_DX1];
   assign rsp_deriv_x2       = rsp_f_ff[D_DX2];
   assign rsp_deriv_x1x1     = rsp_f_ff[D_DX1X1];
   assign rsp_deriv_x1x2     = rsp_f_ff[D_DX1X2];
   assign rsp_deriv_x2x2     = rsp_f_ff[D_DX2X2];
   assign rsp_last_component = rsp_last_ff;

endmodule
